/* rtl/mlfd_pkg.sv */
// Package for the marker/length/stop-marker deframer: widths, codes and helpers.
package mlfd_pkg;

    localparam int MARKER_LEN_DEF = 2;
    localparam int MARKER_LEN_MAX = 4;
    localparam int BYTE_W         = 8;
    localparam int MARKER_W       = BYTE_W * MARKER_LEN_MAX;
    localparam int EVENT_W        = 3;
    localparam int CFG_INDEX_W    = 2;

    typedef enum logic [EVENT_W-1:0] {
        EV_CONSUMED   = 3'd0,
        EV_PAYLOAD    = 3'd1,
        EV_COMPLETE   = 3'd2,
        EV_START_MISS = 3'd3,
        EV_STOP_MISS  = 3'd4
    } event_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_MARKER = 2'd0,
        REG_STOP_MARKER  = 2'd1
    } reg_index_t;

    // Byte pos of a marker word, byte 0 in the low bits.
    function automatic logic [BYTE_W-1:0] marker_byte(input logic [MARKER_W-1:0] marker,
                                                      input logic [1:0] pos);
        marker_byte = marker[BYTE_W*pos +: BYTE_W];
    endfunction

endpackage

/* rtl/marker_length_frame_deframer.sv */
// Top level of the start-marker / length / stop-marker serial deframer.
//
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) takes one received byte per
//   transaction. Output channel (out_valid, out_stall, event_res, payload_byte,
//   payload_index, frame_length) returns exactly one result per input byte:
//   consumed, payload byte with its index, frame complete with its length,
//   or a start/stop marker mismatch. Software treats a frame as good only
//   once the frame-complete event arrives.
//   Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
//   start marker (index 0) and stop marker (index 1); other indexes are
//   dropped. cfg_ready is always high.
// Timing:
//   A byte's result is registered and shows in the cycle after the byte is accepted.
//   Throughput is one byte per cycle while out_stall is low, set by the single result
//   register; the frame state updates in the same cycle the byte is taken.
// Reset:
//   Markers and frame state clear to zero and the result register empties.
// Stall:
//   While a result waits under out_stall, in_stall is raised; a new byte is
//   taken in the same cycle the pending result is taken.
module marker_length_frame_deframer #(
    parameter int MARKER_LEN = mlfd_pkg::MARKER_LEN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mlfd_pkg::BYTE_W-1:0]        rx_byte,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mlfd_pkg::EVENT_W-1:0]       event_res,
    output logic [mlfd_pkg::BYTE_W-1:0]        payload_byte,
    output logic [mlfd_pkg::BYTE_W-1:0]        payload_index,
    output logic [mlfd_pkg::BYTE_W-1:0]        frame_length,
    // config channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mlfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mlfd_pkg::MARKER_W-1:0]      cfg_data
);

    localparam int CNT_W = $clog2(MARKER_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MARKER_LEN);

    logic [mlfd_pkg::MARKER_W-1:0] start_marker_reg;
    logic [mlfd_pkg::MARKER_W-1:0] stop_marker_reg;

    logic [CNT_W-1:0]              start_cnt_reg,  start_cnt_next;
    logic [CNT_W-1:0]              stop_cnt_reg,   stop_cnt_next;
    logic [mlfd_pkg::BYTE_W-1:0]   length_reg,     length_next;
    logic [mlfd_pkg::BYTE_W-1:0]   pay_cnt_reg,    pay_cnt_next;

    logic                          out_valid_reg;
    mlfd_pkg::event_t              event_reg,      event_next;
    logic [mlfd_pkg::BYTE_W-1:0]   pbyte_reg,      pbyte_next;
    logic [mlfd_pkg::BYTE_W-1:0]   pidx_reg,       pidx_next;
    logic [mlfd_pkg::BYTE_W-1:0]   flen_reg,       flen_next;

    logic [1:0]                    start_pos;
    logic [1:0]                    stop_pos;
    logic                          in_accept;
    logic                          out_accept;

    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign cfg_ready  = 1'b1;

    assign start_pos = 2'(start_cnt_reg);
    assign stop_pos  = 2'(stop_cnt_reg);

    always_comb
    begin
        start_cnt_next = start_cnt_reg;
        stop_cnt_next  = stop_cnt_reg;
        length_next    = length_reg;
        pay_cnt_next   = pay_cnt_reg;
        event_next     = mlfd_pkg::EV_CONSUMED;
        pbyte_next     = '0;
        pidx_next      = '0;
        flen_next      = '0;

        if (start_cnt_reg < CNT_FULL)
        begin
            if (mlfd_pkg::marker_byte(start_marker_reg, start_pos) == rx_byte)
            begin
                start_cnt_next = start_cnt_reg + 1'b1;
            end
            else
            begin
                start_cnt_next = '0;
                stop_cnt_next  = '0;
                length_next    = '0;
                pay_cnt_next   = '0;
                event_next     = mlfd_pkg::EV_START_MISS;
            end
        end
        else if (length_reg == '0)
        begin
            // a zero length byte leaves us still waiting for a length
            length_next = rx_byte;
        end
        else if (length_reg > pay_cnt_reg)
        begin
            event_next   = mlfd_pkg::EV_PAYLOAD;
            pbyte_next   = rx_byte;
            pidx_next    = pay_cnt_reg;
            pay_cnt_next = pay_cnt_reg + 1'b1;
        end
        else if (stop_cnt_reg < CNT_FULL)
        begin
            if (mlfd_pkg::marker_byte(stop_marker_reg, stop_pos) == rx_byte)
            begin
                if (stop_cnt_reg + 1'b1 == CNT_FULL)
                begin
                    event_next     = mlfd_pkg::EV_COMPLETE;
                    flen_next      = length_reg;
                    start_cnt_next = '0;
                    stop_cnt_next  = '0;
                    length_next    = '0;
                    pay_cnt_next   = '0;
                end
                else
                begin
                    stop_cnt_next = stop_cnt_reg + 1'b1;
                end
            end
            else
            begin
                start_cnt_next = '0;
                stop_cnt_next  = '0;
                length_next    = '0;
                pay_cnt_next   = '0;
                event_next     = mlfd_pkg::EV_STOP_MISS;
            end
        end
        else
        begin
            start_cnt_next = '0;
            stop_cnt_next  = '0;
            length_next    = '0;
            pay_cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= '0;
            stop_marker_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mlfd_pkg::REG_START_MARKER: start_marker_reg <= cfg_data;
                mlfd_pkg::REG_STOP_MARKER:  stop_marker_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_cnt_reg <= '0;
            stop_cnt_reg  <= '0;
            length_reg    <= '0;
            pay_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                start_cnt_reg <= start_cnt_next;
                stop_cnt_reg  <= stop_cnt_next;
                length_reg    <= length_next;
                pay_cnt_reg   <= pay_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted byte
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            event_reg <= event_next;
            pbyte_reg <= pbyte_next;
            pidx_reg  <= pidx_next;
            flen_reg  <= flen_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = event_reg;
    assign payload_byte  = pbyte_reg;
    assign payload_index = pidx_reg;
    assign frame_length  = flen_reg;

endmodule

/* rtl/mlfd_checker.sv */
// Port-level checker for the deframer, bound to the top level.
module mlfd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [mlfd_pkg::EVENT_W-1:0]      event_res,
    input logic [mlfd_pkg::BYTE_W-1:0]       payload_byte,
    input logic [mlfd_pkg::BYTE_W-1:0]       payload_index,
    input logic [mlfd_pkg::BYTE_W-1:0]       frame_length
);

    // every accepted byte yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("no result after accepted byte");

    // input is held off only while a result is waiting under stall
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with no pending result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(event_res)
                                      && $stable(payload_byte) && $stable(frame_length)))
        else $error("stalled result changed");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res != mlfd_pkg::EV_PAYLOAD)
            |-> (payload_byte == '0 && payload_index == '0))
        else $error("payload fields set on non-payload event");

    a_length_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res != mlfd_pkg::EV_COMPLETE) |-> (frame_length == '0))
        else $error("frame length set on non-complete event");

endmodule

bind marker_length_frame_deframer mlfd_checker u_mlfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .frame_length  (frame_length)
);
